// File: rtl/core/uhc_pkg.sv
// Shared types, constants and helpers for the UDP/IP header compressor.
`timescale 1ns / 1ps

package uhc_pkg;

   // Header hold buffer: MAC (14) + IPv4 (20) + UDP (8) bytes.
   localparam int HoldLen   = 42;
   localparam int HoldAddrW = 6;

   // Byte positions within the held header.
   localparam logic [5:0] POS_PASSING   = 6'd42;
   localparam logic [5:0] POS_LAST_HELD = 6'd41;
   localparam logic [5:0] POS_MIN_LAST  = 6'd13;
   localparam logic [5:0] DST_MAC_FIRST = 6'd0;
   localparam logic [5:0] DST_MAC_LAST  = 6'd5;
   localparam logic [5:0] SRC_MAC_FIRST = 6'd6;
   localparam logic [5:0] SRC_MAC_LAST  = 6'd11;
   localparam logic [5:0] ETYPE_HI      = 6'd12;
   localparam logic [5:0] ETYPE_LO      = 6'd13;
   localparam logic [5:0] IP_VER_IHL    = 6'd14;
   localparam logic [5:0] IPV4_PROTO    = 6'd23;
   localparam logic [5:0] UDP_SPORT_HI  = 6'd34;
   localparam logic [5:0] UDP_SPORT_LO  = 6'd35;
   localparam logic [5:0] UDP_DPORT_HI  = 6'd36;
   localparam logic [5:0] UDP_DPORT_LO  = 6'd37;

   localparam logic [7:0]  TUNNEL_MARK  = 8'h80;
   localparam logic [7:0]  BCAST_CLEAR  = 8'h00;
   localparam logic [15:0] ETYPE_IPV4   = 16'h0800;
   localparam logic [3:0]  IHL_PLAIN    = 4'd5;
   localparam logic [7:0]  PROTO_UDP    = 8'd17;

   localparam logic [7:0]  RESET_RULE_PLAIN  = 8'd0;
   localparam logic [7:0]  RESET_RULE_IP     = 8'd1;
   localparam logic [7:0]  RESET_RULE_IP_UDP = 8'd2;
   localparam logic [15:0] RESET_UDP_PORT    = 16'd47808;

   typedef enum logic [1:0] {
      CSR_RULE_PLAIN  = 2'd0,
      CSR_RULE_IP     = 2'd1,
      CSR_RULE_IP_UDP = 2'd2,
      CSR_UDP_PORT    = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      RULE_PLAIN  = 2'd0,
      RULE_IP     = 2'd1,
      RULE_IP_UDP = 2'd2
   } rule_type;

   typedef enum logic [1:0] {
      CMD_PASS  = 2'd0,
      CMD_SHORT = 2'd1,
      CMD_BURST = 2'd2
   } cmd_kind_type;

   typedef struct packed {
      logic [7:0]  rule_plain;
      logic [7:0]  rule_ip;
      logic [7:0]  rule_ip_udp;
      logic [15:0] udp_port;
   } cfg_type;

   // One work item from the front end to the back end.
   typedef struct packed {
      cmd_kind_type          kind;
      logic [7:0]            data;      // pass-through byte or rule byte
      logic                  last_byte; // frame ends with this item
      logic                  bcast;
      rule_type              rule;
      logic [HoldAddrW-1:0]  last_idx;  // final held byte of a header release
   } cmd_type;

   // Order in which held bytes are released: source MAC, then either the
   // destination MAC and the rest of the held frame, or the UDP header.
   function automatic logic [HoldAddrW-1:0] next_hold_addr(
      input logic [HoldAddrW-1:0] addr,
      input rule_type             rule
   );
      logic [HoldAddrW-1:0] nxt;
      if (addr == SRC_MAC_LAST) begin
         nxt = (rule == RULE_PLAIN) ? DST_MAC_FIRST : UDP_SPORT_HI;
      end else if (addr == DST_MAC_LAST) begin
         nxt = ETYPE_HI;
      end else begin
         nxt = addr + HoldAddrW'(1);
      end
      return nxt;
   endfunction

endpackage

// File: rtl/core/uhc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module uhc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 42
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/uhc_front.sv
// Front end: accepts frame bytes, holds the header and classifies the frame.
`timescale 1ns / 1ps

module uhc_front import uhc_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [7:0]           req_tdata,
   input  logic                 req_tlast,
   input  logic                 req_tuser,
   input  cfg_type              cfg,
   input  logic                 q_full,
   output logic                 q_push,
   output cmd_type              q_cmd,
   output logic                 hold_wr_en,
   output logic [HoldAddrW-1:0] hold_wr_addr,
   output logic [7:0]           hold_wr_data,
   input  logic                 burst_done,
   output logic                 burst_busy
);

   logic [5:0]  pos_ff, pos_in;
   logic        busy_ff, busy_in;
   logic        bcast_ff;
   logic [15:0] etype_ff;
   logic [3:0]  ihl_ff;
   logic [7:0]  proto_ff;
   logic [15:0] sport_ff;
   logic [15:0] dport_ff;

   logic                 passing;
   logic                 accept;
   logic                 held_done;
   logic                 is_udp;
   rule_type             rule;
   logic [7:0]           rule_byte;
   logic [HoldAddrW-1:0] last_idx;

   assign passing    = (pos_ff == POS_PASSING);
   // A new header may not overwrite the hold buffer while it is being released.
   assign req_tready = !q_full && (passing || !busy_ff);
   assign accept     = req_tvalid && req_tready;
   assign held_done  = req_tlast || (pos_ff == POS_LAST_HELD);

   assign hold_wr_en   = accept && !passing;
   assign hold_wr_addr = pos_ff;
   assign hold_wr_data = req_tdata;
   assign burst_busy   = busy_ff;

   assign is_udp = (etype_ff == ETYPE_IPV4) && (ihl_ff == IHL_PLAIN)
                   && (proto_ff == PROTO_UDP);

   always_comb begin
      if ((pos_ff != POS_LAST_HELD) || !is_udp) begin
         rule = RULE_PLAIN;
      end else if ((sport_ff == cfg.udp_port) && (dport_ff == cfg.udp_port)) begin
         rule = RULE_IP_UDP;
      end else begin
         rule = RULE_IP;
      end

      case (rule)
         RULE_IP: begin
            rule_byte = cfg.rule_ip;
            last_idx  = POS_LAST_HELD;
         end
         RULE_IP_UDP: begin
            rule_byte = cfg.rule_ip_udp;
            last_idx  = SRC_MAC_LAST;
         end
         default: begin
            rule_byte = cfg.rule_plain;
            last_idx  = pos_ff;
         end
      endcase
   end

   always_comb begin
      pos_in          = pos_ff;
      busy_in         = busy_ff;
      q_push          = 1'b0;
      q_cmd.kind      = CMD_PASS;
      q_cmd.data      = req_tdata;
      q_cmd.last_byte = req_tlast;
      q_cmd.bcast     = bcast_ff;
      q_cmd.rule      = rule;
      q_cmd.last_idx  = last_idx;

      if (burst_done) begin
         busy_in = 1'b0;
      end

      if (accept) begin
         if (passing) begin
            q_push = 1'b1;
            if (req_tlast) begin
               pos_in = '0;
            end
         end else if (held_done) begin
            q_push = 1'b1;
            if (pos_ff < POS_MIN_LAST) begin
               q_cmd.kind = CMD_SHORT;
               pos_in     = '0;
            end else begin
               q_cmd.kind = CMD_BURST;
               q_cmd.data = rule_byte;
               busy_in    = 1'b1;
               pos_in     = req_tlast ? 6'd0 : POS_PASSING;
            end
         end else begin
            pos_in = pos_ff + 6'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         busy_ff <= 1'b0;
      end else begin
         pos_ff  <= pos_in;
         busy_ff <= busy_in;
      end
   end

   // Header fields needed for classification are captured as they stream in.
   always_ff @(posedge clock) begin
      if (hold_wr_en) begin
         case (pos_ff)
            DST_MAC_FIRST: bcast_ff       <= req_tuser;
            ETYPE_HI:      etype_ff[15:8] <= req_tdata;
            ETYPE_LO:      etype_ff[7:0]  <= req_tdata;
            IP_VER_IHL:    ihl_ff         <= req_tdata[3:0];
            IPV4_PROTO:    proto_ff       <= req_tdata;
            UDP_SPORT_HI:  sport_ff[15:8] <= req_tdata;
            UDP_SPORT_LO:  sport_ff[7:0]  <= req_tdata;
            UDP_DPORT_HI:  dport_ff[15:8] <= req_tdata;
            UDP_DPORT_LO:  dport_ff[7:0]  <= req_tdata;
            default: begin
            end
         endcase
      end
   end

endmodule

// File: rtl/core/uhc_cmd_fifo.sv
// Short command queue between the front end and the back end.
`timescale 1ns / 1ps

module uhc_cmd_fifo import uhc_pkg::*; #(
   parameter int DEPTH = 4
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   input  logic    pop,
   output cmd_type head,
   output logic    empty,
   output logic    full
);

   localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntW = $clog2(DEPTH + 1);

   cmd_type         entries_ff [DEPTH];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic            do_push;
   logic            do_pop;

   assign full    = (count_ff == CntW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + CntW'(1);
         2'b01:   count_in = count_ff - CntW'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// File: rtl/core/uhc_back.sv
// Back end: turns queued commands into tunnel packet bytes.
`timescale 1ns / 1ps

module uhc_back import uhc_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_empty,
   input  cmd_type              q_head,
   output logic                 q_pop,
   output logic                 hold_rd_en,
   output logic [HoldAddrW-1:0] hold_rd_addr,
   input  logic [7:0]           hold_rd_data,
   output logic                 burst_done,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [7:0]           rsp_tdata,
   output logic                 rsp_tlast,
   output logic                 rsp_tuser
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_HEADER,
      ST_READ,
      ST_STREAM
   } state_type;

   localparam logic [1:0] HDR_FLAG = 2'd0;
   localparam logic [1:0] HDR_MARK = 2'd1;
   localparam logic [1:0] HDR_RULE = 2'd2;

   state_type            state_ff, state_in;
   logic [1:0]           hdr_cnt_ff, hdr_cnt_in;
   logic [HoldAddrW-1:0] addr_ff, addr_in;
   logic [HoldAddrW-1:0] last_idx_ff, last_idx_in;
   rule_type             rule_ff, rule_in;
   logic [7:0]           rule_byte_ff, rule_byte_in;
   logic                 bcast_ff, bcast_in;
   logic                 end_ff, end_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [7:0]           rsp_data_ff, rsp_data_in;
   logic                 rsp_last_ff, rsp_last_in;
   logic                 rsp_user_ff, rsp_user_in;

   logic                 out_free;
   logic                 at_last;
   logic [HoldAddrW-1:0] next_addr;

   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign at_last   = (addr_ff == last_idx_ff);
   assign next_addr = next_hold_addr(addr_ff, rule_ff);

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_user_ff;

   always_comb begin
      state_in     = state_ff;
      hdr_cnt_in   = hdr_cnt_ff;
      addr_in      = addr_ff;
      last_idx_in  = last_idx_ff;
      rule_in      = rule_ff;
      rule_byte_in = rule_byte_ff;
      bcast_in     = bcast_ff;
      end_in       = end_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_user_in  = rsp_user_ff;
      q_pop        = 1'b0;
      hold_rd_en   = 1'b0;
      hold_rd_addr = addr_ff;
      burst_done   = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               case (q_head.kind)
                  CMD_BURST: begin
                     q_pop        = 1'b1;
                     rule_in      = q_head.rule;
                     rule_byte_in = q_head.data;
                     bcast_in     = q_head.bcast;
                     end_in       = q_head.last_byte;
                     last_idx_in  = q_head.last_idx;
                     hdr_cnt_in   = HDR_FLAG;
                     state_in     = ST_HEADER;
                  end
                  CMD_SHORT: begin
                     if (out_free) begin
                        q_pop        = 1'b1;
                        rsp_valid_in = 1'b1;
                        rsp_data_in  = '0;
                        rsp_last_in  = 1'b1;
                        rsp_user_in  = 1'b1;
                     end
                  end
                  default: begin
                     if (out_free) begin
                        q_pop        = 1'b1;
                        rsp_valid_in = 1'b1;
                        rsp_data_in  = q_head.data;
                        rsp_last_in  = q_head.last_byte;
                        rsp_user_in  = 1'b0;
                     end
                  end
               endcase
            end
         end
         ST_HEADER: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_last_in  = 1'b0;
               rsp_user_in  = 1'b0;
               case (hdr_cnt_ff)
                  HDR_FLAG: rsp_data_in = bcast_ff ? TUNNEL_MARK : BCAST_CLEAR;
                  HDR_MARK: rsp_data_in = TUNNEL_MARK;
                  default:  rsp_data_in = rule_byte_ff;
               endcase
               if (hdr_cnt_ff == HDR_RULE) begin
                  addr_in  = SRC_MAC_FIRST;
                  state_in = ST_READ;
               end else begin
                  hdr_cnt_in = hdr_cnt_ff + 2'd1;
               end
            end
         end
         ST_READ: begin
            hold_rd_en = 1'b1;
            state_in   = ST_STREAM;
         end
         ST_STREAM: begin
            // Read data stays put while the output is stalled; the next
            // address is fetched as each byte moves to the output register.
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = hold_rd_data;
               rsp_last_in  = at_last && end_ff;
               rsp_user_in  = 1'b0;
               if (at_last) begin
                  burst_done = 1'b1;
                  state_in   = ST_IDLE;
               end else begin
                  addr_in      = next_addr;
                  hold_rd_en   = 1'b1;
                  hold_rd_addr = next_addr;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      hdr_cnt_ff   <= hdr_cnt_in;
      addr_ff      <= addr_in;
      last_idx_ff  <= last_idx_in;
      rule_ff      <= rule_in;
      rule_byte_ff <= rule_byte_in;
      bcast_ff     <= bcast_in;
      end_ff       <= end_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_user_ff  <= rsp_user_in;
   end

endmodule

// File: rtl/core/udp_ip_header_compressor_unit.sv
// Top level of the UDP/IP header compressor: CSRs and block wiring.
//
// Frame bytes enter on the req_ channel one per transfer, tlast on the last
// byte and tuser carrying the broadcast flag of the frame's first byte. The
// first 42 bytes are held in a header RAM; when the 42nd byte or the frame
// end arrives, the frame is classified and a tunnel packet goes out on the
// rsp_ channel: broadcast byte, 0x80, rule byte, source MAC, then the kept
// header bytes and the rest of the frame. A frame under 14 bytes gives a
// single transfer with tuser (too short) and tlast set.
// A pass-through byte reaches rsp_ through the command queue and the output
// register. A header release passes through the queue and the header states,
// then gives one byte per cycle while rsp_tready is high, with a gap after
// the rule byte while the first held byte is read from the RAM. Pass-through
// bytes flow at one per cycle while rsp_tready is high. The next frame's
// header is not accepted until the previous release has left the RAM. The
// CSR port (csr_) is always ready; it is to be written only while idle,
// which the user must ensure; the block does not enforce it. Reset clears
// the byte counter, the command queue and the output register and loads the
// CSR defaults; the header RAM needs no clearing. When the receiver stalls,
// the output register holds, the command queue fills and req_tready falls.
`timescale 1ns / 1ps

module udp_ip_header_compressor_unit import uhc_pkg::*; #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] frame_byte
   input  logic        req_tlast,   // frame_end
   input  logic        req_tuser,   // [0] broadcast_flag
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] out_byte
   output logic        rsp_tlast,   // out_end
   output logic        rsp_tuser,   // [0] too_short
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);

   cfg_type cfg_ff, cfg_in;

   logic                 q_push;
   cmd_type              q_cmd;
   logic                 q_pop;
   cmd_type              q_head;
   logic                 q_empty;
   logic                 q_full;
   logic                 hold_wr_en;
   logic [HoldAddrW-1:0] hold_wr_addr;
   logic [7:0]           hold_wr_data;
   logic                 hold_rd_en;
   logic [HoldAddrW-1:0] hold_rd_addr;
   logic [7:0]           hold_rd_data;
   logic                 burst_done;
   logic                 burst_busy;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_RULE_PLAIN:  cfg_in.rule_plain  = csr_data[7:0];
            CSR_RULE_IP:     cfg_in.rule_ip     = csr_data[7:0];
            CSR_RULE_IP_UDP: cfg_in.rule_ip_udp = csr_data[7:0];
            CSR_UDP_PORT:    cfg_in.udp_port    = csr_data;
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rule_plain  <= RESET_RULE_PLAIN;
         cfg_ff.rule_ip     <= RESET_RULE_IP;
         cfg_ff.rule_ip_udp <= RESET_RULE_IP_UDP;
         cfg_ff.udp_port    <= RESET_UDP_PORT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   uhc_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tlast    (req_tlast),
      .req_tuser    (req_tuser),
      .cfg          (cfg_ff),
      .q_full       (q_full),
      .q_push       (q_push),
      .q_cmd        (q_cmd),
      .hold_wr_en   (hold_wr_en),
      .hold_wr_addr (hold_wr_addr),
      .hold_wr_data (hold_wr_data),
      .burst_done   (burst_done),
      .burst_busy   (burst_busy)
   );

   uhc_ram #(
      .WIDTH (8),
      .DEPTH (HoldLen)
   ) u_hold_ram (
      .clock   (clock),
      .wr_en   (hold_wr_en),
      .wr_addr (hold_wr_addr),
      .wr_data (hold_wr_data),
      .rd_en   (hold_rd_en),
      .rd_addr (hold_rd_addr),
      .rd_data (hold_rd_data)
   );

   uhc_cmd_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_cmd_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (q_cmd),
      .pop      (q_pop),
      .head     (q_head),
      .empty    (q_empty),
      .full     (q_full)
   );

   uhc_back u_back (
      .clock        (clock),
      .reset        (reset),
      .q_empty      (q_empty),
      .q_head       (q_head),
      .q_pop        (q_pop),
      .hold_rd_en   (hold_rd_en),
      .hold_rd_addr (hold_rd_addr),
      .hold_rd_data (hold_rd_data),
      .burst_done   (burst_done),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tlast    (rsp_tlast),
      .rsp_tuser    (rsp_tuser)
   );

`ifndef SYNTH
   // The back end only finishes a header release that the front end started.
   a_done_needs_busy: assert property (@(posedge clock) disable iff (reset)
      burst_done |-> burst_busy)
      else $error("header release finished with none pending");

   // The front end never offers a command to a full queue.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("command queue overflow");

   // The header RAM is not rewritten while a release reads it.
   a_hold_stable: assert property (@(posedge clock) disable iff (reset)
      hold_wr_en |-> !burst_busy)
      else $error("header RAM written during release");

   // A too-short result is always a packet of its own.
   a_short_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> rsp_tlast)
      else $error("too-short result without tlast");
`endif

endmodule
